// ===== design/osr_pkg.sv =====
// ----------------------------------------------------------------------------
// osr_pkg
// Types and constants shared by the out-of-range slot reassigner modules.
// ----------------------------------------------------------------------------
package osr_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int CNT_W     = 11;
  localparam int POS_W     = 32;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  typedef enum logic [1:0] {
    STATUS_UNCHANGED = 2'd0,
    STATUS_MODIFIED  = 2'd1,
    STATUS_NO_SPACE  = 2'd2
  } run_status_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] final_position;
    logic             was_moved;
    run_status_t      run_status;
    logic             last_out;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MARK,
    ST_SCAN,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load_in;
    logic rd_pos;
    logic rd_top;
    logic rd_next;
    logic write_mark;
    logic write_found;
    logic set_oos;
    logic load_out;
  } osr_cmd_t;

  typedef struct packed {
    logic oos;
    logic in_range;
    logic eff_zero;
    logic found;
    logic at_word0;
    logic out_free;
  } osr_status_t;

endpackage

// ===== design/osr_ram.sv =====
// ----------------------------------------------------------------------------
// osr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module osr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/osr_dp.sv =====
// ----------------------------------------------------------------------------
// osr_dp
// Datapath: slot count register, occupancy map words with per-word valid
// bits, downward free-slot search, run status and result register.
// ----------------------------------------------------------------------------
module osr_dp
  import osr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  osr_cmd_t          cmd,
  output osr_status_t       status,
  input  item_t             item,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  logic [CNT_W-1:0]     slot_count;
  logic [POS_W-1:0]     pos_q;
  logic                 last_q;
  logic [POS_W-1:0]     res_pos;
  logic                 res_moved;
  logic                 any_moved;
  logic                 out_of_space;
  logic [NUM_WORDS-1:0] word_valid;
  logic [WIDX_W-1:0]    rd_addr_q;

  logic [POS_W-1:0]     eff;
  logic [POS_W-1:0]     eff_m1;
  logic [WIDX_W-1:0]    top_word;
  logic [WIDX_W-1:0]    pos_word;
  logic [WORD_BITS-1:0] top_mask;
  logic [WORD_BITS-1:0] ram_rd;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     free_idx;
  logic [BIT_W-1:0]     wr_bit;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 out_free;
  logic                 clear_run;
  run_status_t          run_status;

  always_comb begin
    if (POS_W'(slot_count) > POS_W'(MAX_SLOTS)) begin
      eff = POS_W'(MAX_SLOTS);
    end else begin
      eff = POS_W'(slot_count);
    end
  end

  assign eff_m1   = eff - POS_W'(1);
  assign top_word = eff_m1[BIT_W +: WIDX_W];
  assign pos_word = pos_q[BIT_W +: WIDX_W];
  assign top_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - eff_m1[BIT_W-1:0]);

  assign rd_word   = word_valid[rd_addr_q] ? ram_rd : '0;
  assign free_bits = ~rd_word & ((rd_addr_q == top_word) ? top_mask : {WORD_BITS{1'b1}});

  always_comb begin
    free_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (free_bits[b]) begin
        free_idx = BIT_W'(b);
      end
    end
  end

  always_comb begin
    priority if (cmd.rd_pos) begin
      rd_addr = pos_word;
    end else if (cmd.rd_top) begin
      rd_addr = top_word;
    end else begin
      rd_addr = rd_addr_q - WIDX_W'(1);
    end
  end

  assign rd_en   = cmd.rd_pos | cmd.rd_top | cmd.rd_next;
  assign wr_en   = cmd.write_mark | cmd.write_found;
  assign wr_bit  = cmd.write_mark ? pos_q[BIT_W-1:0] : free_idx;
  assign wr_data = rd_word | (WORD_BITS'(1) << wr_bit);

  osr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_addr_q),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  assign out_free  = !result_valid || !result_stall;
  assign clear_run = cmd.load_out && last_q;

  always_comb begin
    priority if (out_of_space) begin
      run_status = STATUS_NO_SPACE;
    end else if (any_moved) begin
      run_status = STATUS_MODIFIED;
    end else begin
      run_status = STATUS_UNCHANGED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= CNT_W'(1024);
      any_moved    <= 1'b0;
      out_of_space <= 1'b0;
      word_valid   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        slot_count <= cfg_data;
      end
      if (clear_run) begin
        any_moved    <= 1'b0;
        out_of_space <= 1'b0;
        word_valid   <= '0;
      end else begin
        if (cmd.write_found) begin
          any_moved <= 1'b1;
        end
        if (cmd.set_oos) begin
          out_of_space <= 1'b1;
        end
        if (wr_en) begin
          word_valid[rd_addr_q] <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_q     <= item.position;
      last_q    <= item.last;
      res_pos   <= item.position;
      res_moved <= 1'b0;
    end else if (cmd.write_found) begin
      res_pos   <= POS_W'({rd_addr_q, free_idx});
      res_moved <= 1'b1;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd.load_out) begin
      result.final_position <= res_pos;
      result.was_moved      <= res_moved;
      result.run_status     <= run_status;
      result.last_out       <= last_q;
    end
  end

  assign status.oos      = out_of_space;
  assign status.in_range = pos_q < eff;
  assign status.eff_zero = eff == '0;
  assign status.found    = |free_bits;
  assign status.at_word0 = rd_addr_q == '0;
  assign status.out_free = out_free;

  a_no_move_after_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write_found |-> !out_of_space)
    else $error("slot reassigned after no-space latched");

  a_found_marks_moved: assert property (@(posedge clk) disable iff (rst)
    cmd.write_found |=> res_moved && res_pos < eff)
    else $error("reassigned slot not recorded or out of range");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    clear_run |=> word_valid == '0 && !any_moved && !out_of_space)
    else $error("run state not cleared after last word");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result register overwritten while stalled");

endmodule

// ===== design/osr_ctrl.sv =====
// ----------------------------------------------------------------------------
// osr_ctrl
// Controller: sequences accept, range decision, map update or downward
// word scan, and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
module osr_ctrl
  import osr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  osr_status_t status,
  output osr_cmd_t    cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.oos) begin
          state_next = ST_DONE;
        end else if (status.in_range) begin
          state_next = ST_MARK;
        end else if (status.eff_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_MARK: begin
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (status.found || status.at_word0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.load_in = item_valid;
      end
      ST_DECIDE: begin
        priority if (status.oos) begin
          cmd = '0;
        end else if (status.in_range) begin
          cmd.rd_pos = 1'b1;
        end else if (status.eff_zero) begin
          cmd.set_oos = 1'b1;
        end else begin
          cmd.rd_top = 1'b1;
        end
      end
      ST_MARK: begin
        cmd.write_mark = 1'b1;
      end
      ST_SCAN: begin
        priority if (status.found) begin
          cmd.write_found = 1'b1;
        end else if (status.at_word0) begin
          cmd.set_oos = 1'b1;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_idle_only: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> state == ST_DECIDE)
    else $error("accepted word did not start decision");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_pos, cmd.rd_top, cmd.rd_next, cmd.write_mark, cmd.set_oos}))
    else $error("conflicting map commands");

  a_scan_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SCAN) |-> $past(cmd.rd_top))
    else $error("scan entered without top word read");

endmodule

// ===== design/out_of_range_slot_reassigner.sv =====
// ----------------------------------------------------------------------------
// out_of_range_slot_reassigner
// Reassigns out-of-range slot positions to the highest free slot of a run.
// ----------------------------------------------------------------------------
// One word is handled at a time; the next word is accepted only after the
// result of the last one is handed off. A position below the slot count
// marks its slot in the map; a word after no-space passes unchanged; a
// reassigned word scans 32-slot map words downward from the top of the
// slot count (1 to 32 at 1024 slots). The scan reads through the single
// read port of the occupancy map RAM, which delivers one 32-slot word per
// cycle. The map needs no clearing pass: per-word valid bits clear at reset
// and after the last word of a run. Write cfg_data only while idle.
module out_of_range_slot_reassigner
  import osr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  osr_cmd_t    cmd;
  osr_status_t status;

  assign cfg_ready = 1'b1;

  osr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  osr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
